// ----- rtl/core/akf_pkg.sv -----
// Package: shared widths, reset constants, register index codes and fixed-point helpers.
package akf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgW  = 31;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned FracQ24 = 24;

  localparam logic [CfgW-1:0] TimeStepRst     = 31'd83886;
  localparam logic [CfgW-1:0] AngleNoiseRst   = 31'd16777;
  localparam logic [CfgW-1:0] BiasNoiseRst    = 31'd50332;
  localparam logic [CfgW-1:0] MeasureNoiseRst = 31'd8388608;
  localparam logic signed [DataW-1:0] OneQ24  = 32'sd16777216;

  localparam logic [CfgIdxW-1:0] RegTimeStep     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAngleNoise   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBiasNoise    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMeasureNoise = 2'd3;

  // Divider: 56-bit magnitude dividend (<= 2^31 * 2^24 = 2^55), 33-bit divisor, 56-bit quotient.
  localparam int unsigned DivNumW = 56;
  localparam int unsigned DivDenW = 33;
  localparam int unsigned DivCntW = 6;

  // Multiplier operand is 34 bits signed to cover |a| <= 2^32.
  localparam int unsigned MulAW = 34;
  localparam int unsigned MulPW = 66;
  // Shifted product plus a 32-bit addend, before saturation.
  localparam int unsigned SumW = MulPW - FracQ24 + 1;

  typedef struct packed {
    logic start;
    logic signed [DivNumW:0] num;   // signed numerator * 2^24
    logic [DivDenW-1:0] den;        // positive denominator
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [DataW-1:0] gain;  // clamped quotient
  } div_rsp_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [SumW-1:0] x);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(64'sd2147483647);
    lo = SumW'(-64'sd2147483648);
    if (x > hi) return 32'sh7fffffff;
    if (x < lo) return 32'sh80000000;
    return x[DataW-1:0];
  endfunction

endpackage

// ----- rtl/core/angle_kalman_fusion.sv -----
// Top level: two-state angle/gyro-bias Kalman filter with a shared multiplier and divider.
//
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+-----------------------
//  in      | in_valid, in_stall, accel_angle, gyro_rate| in  | valid & !stall
//  out     | out_valid, out_stall, filtered_angle,     | out | valid & !stall
//          | corrected_rate, bias_estimate             |     |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in  | valid & ready
//
// A sample runs from accept through 10 multiplies on the one registered
// multiplier (S_MUL, then S_WAIT), two gain divisions (start, 56 quotient
// bits, done), then S_OUT and S_HOLD; the divisions take most of the time.
// A non-positive innovation skips both divisions. in_stall is high from
// accept until the result register is free again; the result register holds
// while out_stall is high.
// Synchronous reset restores the default registers and the initial filter state.
module angle_kalman_fusion (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [akf_pkg::DataW-1:0] accel_angle,
  input  logic signed [akf_pkg::DataW-1:0] gyro_rate,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [akf_pkg::DataW-1:0] filtered_angle,
  output logic signed [akf_pkg::DataW-1:0] corrected_rate,
  output logic signed [akf_pkg::DataW-1:0] bias_estimate,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [akf_pkg::DataW-1:0] cfg_index,
  input  logic [akf_pkg::DataW-1:0] cfg_data
);
  typedef logic signed [akf_pkg::DataW-1:0] s32_t;
  typedef logic signed [akf_pkg::SumW-1:0] sum_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,   // issue multiply for step
    S_WAIT  = 7'b0000100,   // multiplier result registered
    S_DIV   = 7'b0001000,   // start divide
    S_DWAIT = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_HOLD  = 7'b1000000
  } state_t;

  state_t state;
  logic [3:0] step;          // multiply step index
  logic div_sel;             // 0: k0, 1: k1

  logic [akf_pkg::CfgW-1:0] time_step, angle_noise, bias_noise, measure_noise;
  s32_t angle_est, bias_est, cov_aa, cov_ab, cov_ba, cov_bb;
  s32_t accel, gyro;
  s32_t apred, p00, p01, p10, p11, k0, k1, d0, d1;
  logic signed [akf_pkg::DataW+1:0] e_sum;

  logic signed [akf_pkg::MulAW-1:0] mul_a;
  s32_t mul_b;
  sum_t mul_q;
  akf_pkg::div_req_t div_req;
  akf_pkg::div_rsp_t div_rsp;

  akf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .q(mul_q));
  akf_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign cfg_ready = (state == S_IDLE);
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    e_sum = (akf_pkg::DataW+2)'($signed({1'b0, measure_noise})) + (akf_pkg::DataW+2)'(p00);
  end

  // Operand select for each multiply step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      4'd0: begin mul_a = akf_pkg::MulAW'(gyro) - akf_pkg::MulAW'(bias_est);
                  mul_b = $signed({1'b0, time_step}); end
      4'd1: begin mul_a = akf_pkg::MulAW'(d0); mul_b = $signed({1'b0, time_step}); end
      4'd2: begin mul_a = akf_pkg::MulAW'(d1); mul_b = $signed({1'b0, time_step}); end
      4'd3: begin mul_a = $signed({3'b0, bias_noise}); mul_b = $signed({1'b0, time_step}); end
      4'd4: begin mul_a = akf_pkg::MulAW'(k0); mul_b = p00; end
      4'd5: begin mul_a = akf_pkg::MulAW'(k0); mul_b = p01; end
      4'd6: begin mul_a = akf_pkg::MulAW'(k1); mul_b = p00; end
      4'd7: begin mul_a = akf_pkg::MulAW'(k1); mul_b = p01; end
      4'd8: begin mul_a = akf_pkg::MulAW'(accel) - akf_pkg::MulAW'(apred); mul_b = k0; end
      4'd9: begin mul_a = akf_pkg::MulAW'(accel) - akf_pkg::MulAW'(apred); mul_b = k1; end
      default: ;
    endcase
  end

  always_comb begin
    div_req.start = (state == S_DIV);
    div_req.num   = div_sel ? (akf_pkg::DivNumW+1)'(p10) <<< akf_pkg::FracQ24
                            : (akf_pkg::DivNumW+1)'(p00) <<< akf_pkg::FracQ24;
    div_req.den   = e_sum[akf_pkg::DivDenW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      time_step <= akf_pkg::TimeStepRst;
      angle_noise <= akf_pkg::AngleNoiseRst;
      bias_noise <= akf_pkg::BiasNoiseRst;
      measure_noise <= akf_pkg::MeasureNoiseRst;
      angle_est <= '0;
      bias_est <= '0;
      cov_aa <= akf_pkg::OneQ24;
      cov_ab <= '0;
      cov_ba <= '0;
      cov_bb <= akf_pkg::OneQ24;
    end else begin
      // load a new result, or clear after a transfer
      if (state == S_HOLD && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          32'(akf_pkg::RegTimeStep):     time_step     <= cfg_data[akf_pkg::CfgW-1:0];
          32'(akf_pkg::RegAngleNoise):   angle_noise   <= cfg_data[akf_pkg::CfgW-1:0];
          32'(akf_pkg::RegBiasNoise):    bias_noise    <= cfg_data[akf_pkg::CfgW-1:0];
          32'(akf_pkg::RegMeasureNoise): measure_noise <= cfg_data[akf_pkg::CfgW-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          accel <= accel_angle;
          gyro  <= gyro_rate;
          d0 <= akf_pkg::sat32(akf_pkg::SumW'($signed({1'b0, angle_noise}))
                               - akf_pkg::SumW'(cov_ab) - akf_pkg::SumW'(cov_ba));
          d1 <= akf_pkg::sat32(-akf_pkg::SumW'(cov_bb));
          step <= 4'd0;
          state <= S_MUL;
        end
        S_MUL: state <= S_WAIT;
        S_WAIT: begin
          state <= S_MUL;
          step <= step + 4'd1;
          case (step)
            4'd0: apred <= akf_pkg::sat32(akf_pkg::SumW'(angle_est) + mul_q);
            4'd1: p00 <= akf_pkg::sat32(akf_pkg::SumW'(cov_aa) + mul_q);
            4'd2: begin
              p01 <= akf_pkg::sat32(akf_pkg::SumW'(cov_ab) + mul_q);
              p10 <= akf_pkg::sat32(akf_pkg::SumW'(cov_ba) + mul_q);
            end
            4'd3: begin
              p11 <= akf_pkg::sat32(akf_pkg::SumW'(cov_bb) + mul_q);
              k0 <= '0;
              k1 <= '0;
              div_sel <= 1'b0;
              state <= S_DIV;
            end
            4'd4: cov_aa <= akf_pkg::sat32(akf_pkg::SumW'(p00) - mul_q);
            4'd5: cov_ab <= akf_pkg::sat32(akf_pkg::SumW'(p01) - mul_q);
            4'd6: cov_ba <= akf_pkg::sat32(akf_pkg::SumW'(p10) - mul_q);
            4'd7: cov_bb <= akf_pkg::sat32(akf_pkg::SumW'(p11) - mul_q);
            4'd8: angle_est <= akf_pkg::sat32(akf_pkg::SumW'(apred) + mul_q);
            4'd9: begin
              bias_est <= akf_pkg::sat32(akf_pkg::SumW'(bias_est) + mul_q);
              state <= S_OUT;
            end
            default: ;
          endcase
        end
        S_DIV: begin
          state <= (e_sum > 0) ? S_DWAIT : S_MUL;
        end
        S_DWAIT: if (div_rsp.done) begin
          if (!div_sel) begin
            k0 <= div_rsp.gain;
            div_sel <= 1'b1;
            state <= S_DIV;
          end else begin
            k1 <= div_rsp.gain;
            state <= S_MUL;
          end
        end
        S_OUT: state <= S_HOLD;
        S_HOLD: if (!out_valid || !out_stall) begin
          filtered_angle <= angle_est;
          bias_estimate  <= bias_est;
          corrected_rate <= akf_pkg::sat32(akf_pkg::SumW'(gyro) - akf_pkg::SumW'(bias_est));
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/core/akf_mul.sv -----
// Shared multiplier: one signed 34x32 Q8.24 product with round-half-up, registered.
module akf_mul (
  input  logic clk,
  input  logic signed [akf_pkg::MulAW-1:0] a,
  input  logic signed [akf_pkg::DataW-1:0] b,
  output logic signed [akf_pkg::SumW-1:0] q
);
  logic signed [akf_pkg::MulPW-1:0] prod;
  logic signed [akf_pkg::MulPW-1:0] rnd;

  always_comb begin
    prod = akf_pkg::MulPW'(a) * akf_pkg::MulPW'(b);
    rnd  = prod + akf_pkg::MulPW'(64'sd8388608);
  end

  // Arithmetic shift is floor division; |product| <= 2^63 keeps the result in 40 bits.
  always_ff @(posedge clk) begin
    q <= akf_pkg::SumW'(rnd >>> akf_pkg::FracQ24);
  end
endmodule

// ----- rtl/core/akf_div.sv -----
// Gain divider: restoring radix-2, one quotient bit per cycle, truncating toward zero.
module akf_div (
  input  logic clk,
  input  logic rst,
  input  akf_pkg::div_req_t req,
  output akf_pkg::div_rsp_t rsp
);
  logic [akf_pkg::DivNumW-1:0] quo;
  logic [akf_pkg::DivDenW:0]   rem;
  logic [akf_pkg::DivDenW-1:0] den;
  logic neg;
  logic busy;
  logic done;
  logic [akf_pkg::DivCntW-1:0] cnt;
  logic [akf_pkg::DivDenW:0] trial;
  logic [akf_pkg::DivDenW:0] shifted;
  logic [akf_pkg::DivNumW-1:0] mag;
  logic [akf_pkg::DataW-1:0] m;

  always_comb begin
    mag = req.num[akf_pkg::DivNumW] ? akf_pkg::DivNumW'(-req.num)
                                    : req.num[akf_pkg::DivNumW-1:0];
    shifted = {rem[akf_pkg::DivDenW-1:0], quo[akf_pkg::DivNumW-1]};
    trial = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == akf_pkg::DivCntW'(akf_pkg::DivNumW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= mag;
      rem <= '0;
      den <= req.den;
      neg <= req.num[akf_pkg::DivNumW];
    end else if (busy) begin
      if (!trial[akf_pkg::DivDenW]) begin
        rem <= trial;
        quo <= {quo[akf_pkg::DivNumW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[akf_pkg::DivNumW-2:0], 1'b0};
      end
    end
  end

  // Clamp magnitude to 2^31-1, then apply the sign.
  always_comb begin
    m = (quo > akf_pkg::DivNumW'(32'h7fffffff)) ? 32'h7fffffff : quo[akf_pkg::DataW-1:0];
    rsp.done = done;
    rsp.gain = neg ? -$signed(m) : $signed(m);
  end
endmodule

// ----- bench/tb_angle_kalman_fusion.sv -----
// Testbench for angle_kalman_fusion: random and directed IMU samples checked against a predictor.
module tb_angle_kalman_fusion;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SatHi = 64'sd2147483647;
  localparam longint SatLo = -64'sd2147483648;
  localparam int CycleLimit = 1000000;
  localparam int IgnoredIdx = 5;        // index beyond the last register, must be dropped
  localparam int RandItems = 1080;
  localparam int PhaseCount = 10;

  typedef struct {
    logic signed [akf_pkg::DataW-1:0] angle;
    logic signed [akf_pkg::DataW-1:0] rate;
    logic signed [akf_pkg::DataW-1:0] bias;
  } fused_t;

  // Kalman predictor plus the queue of fused samples still owed by the block.
  class kalman_scoreboard;
    logic [akf_pkg::CfgW-1:0] dt, q_angle, q_bias, r_meas;
    logic signed [akf_pkg::DataW-1:0] ang, bias, paa, pab, pba, pbb;
    fused_t pending[$];
    int mismatches;
    int checked;

    function new();
      dt = akf_pkg::TimeStepRst;
      q_angle = akf_pkg::AngleNoiseRst;
      q_bias = akf_pkg::BiasNoiseRst;
      r_meas = akf_pkg::MeasureNoiseRst;
      ang = 0;
      bias = 0;
      paa = akf_pkg::OneQ24;
      pab = 0;
      pba = 0;
      pbb = akf_pkg::OneQ24;
      mismatches = 0;
      checked = 0;
    endfunction

    function longint clamp32(longint x);
      if (x > SatHi) return SatHi;
      if (x < SatLo) return SatLo;
      return x;
    endfunction

    // Q8.24 product, round half up
    function longint mul_q24(longint a, longint b);
      return (a * b + 64'sd8388608) >>> akf_pkg::FracQ24;
    endfunction

    function longint kgain(longint num, longint den);
      longint g;
      g = (num * 64'sd16777216) / den;
      if (g > SatHi) g = SatHi;
      if (g < -SatHi) g = -SatHi;
      return g;
    endfunction

    function void write_reg(int idx, logic [akf_pkg::DataW-1:0] val);
      case (idx)
        akf_pkg::RegTimeStep:     dt = val[akf_pkg::CfgW-1:0];
        akf_pkg::RegAngleNoise:   q_angle = val[akf_pkg::CfgW-1:0];
        akf_pkg::RegBiasNoise:    q_bias = val[akf_pkg::CfgW-1:0];
        akf_pkg::RegMeasureNoise: r_meas = val[akf_pkg::CfgW-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [akf_pkg::DataW-1:0] accel,
                              logic signed [akf_pkg::DataW-1:0] gyro);
      longint apred, d0, d1, p00, p01, p10, p11, e, k0, k1, err, dtl;
      fused_t f;
      dtl = longint'(dt);
      apred = clamp32(longint'(ang) + mul_q24(longint'(gyro) - longint'(bias), dtl));
      d0 = clamp32(longint'(q_angle) - longint'(pab) - longint'(pba));
      d1 = clamp32(-longint'(pbb));
      p00 = clamp32(longint'(paa) + mul_q24(d0, dtl));
      p01 = clamp32(longint'(pab) + mul_q24(d1, dtl));
      p10 = clamp32(longint'(pba) + mul_q24(d1, dtl));
      p11 = clamp32(longint'(pbb) + mul_q24(longint'(q_bias), dtl));
      e = longint'(r_meas) + p00;
      // non-positive innovation: no correction at all
      if (e > 0) begin
        k0 = kgain(p00, e);
        k1 = kgain(p10, e);
      end else begin
        k0 = 0;
        k1 = 0;
      end
      err = longint'(accel) - apred;
      paa = 32'(clamp32(p00 - mul_q24(k0, p00)));
      pab = 32'(clamp32(p01 - mul_q24(k0, p01)));
      pba = 32'(clamp32(p10 - mul_q24(k1, p00)));
      pbb = 32'(clamp32(p11 - mul_q24(k1, p01)));
      ang = 32'(clamp32(apred + mul_q24(err, k0)));
      bias = 32'(clamp32(longint'(bias) + mul_q24(err, k1)));
      f.angle = ang;
      f.rate = 32'(clamp32(longint'(gyro) - longint'(bias)));
      f.bias = bias;
      pending.push_back(f);
    endfunction

    function void check_result(fused_t got);
      fused_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result angle=%0d rate=%0d bias=%0d",
                   got.angle, got.rate, got.bias);
        return;
      end
      want = pending.pop_front();
      if (got.angle !== want.angle || got.rate !== want.rate || got.bias !== want.bias) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: angle %0d/%0d rate %0d/%0d bias %0d/%0d (exp/got)",
                   checked, want.angle, got.angle, want.rate, got.rate,
                   want.bias, got.bias);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [akf_pkg::DataW-1:0] accel_angle = '0;
  logic signed [akf_pkg::DataW-1:0] gyro_rate = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [akf_pkg::DataW-1:0] filtered_angle, corrected_rate, bias_estimate;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [akf_pkg::DataW-1:0] cfg_index = '0;
  logic [akf_pkg::DataW-1:0] cfg_data = '0;

  kalman_scoreboard sb = new();
  int cycles = 0;
  int samples_sent = 0;
  int reg_writes = 0;
  bit hold_rx = 1'b0;    // long receiver hold-off
  bit no_gaps = 1'b0;    // phases where both sides run back to back

  angle_kalman_fusion DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .accel_angle(accel_angle), .gyro_rate(gyro_rate),
    .out_valid(out_valid), .out_stall(out_stall),
    .filtered_angle(filtered_angle), .corrected_rate(corrected_rate),
    .bias_estimate(bias_estimate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Output monitor: every result transfer goes to the scoreboard.
  bit took_result = 1'b0;
  always @(posedge clk) begin
    took_result <= (!rst && out_valid && !out_stall);
    if (!rst && out_valid && !out_stall) begin
      fused_t f;
      f.angle = filtered_angle;
      f.rate = corrected_rate;
      f.bias = bias_estimate;
      sb.check_result(f);
    end
  end

  // Receiver: draws a random stall after each result, on top of the long hold-off.
  int rx_wait = 0;
  always @(negedge clk) begin
    if (took_result || rst) rx_wait = no_gaps ? 0 : $urandom_range(0, 4);
    out_stall = rst || hold_rx || (rx_wait > 0);
    if (rx_wait > 0) rx_wait--;
  end

  // Pressure: hold the result side for a long stretch while samples keep coming.
  initial begin
    int n;
    wait (samples_sent >= 300);
    @(negedge clk);
    hold_rx = 1'b1;
    for (n = 0; n < 800; n++) @(negedge clk);
    hold_rx = 1'b0;
  end

  // Entered and left at a falling edge.
  task automatic send_sample(logic signed [akf_pkg::DataW-1:0] a,
                             logic signed [akf_pkg::DataW-1:0] g);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    accel_angle = a;
    gyro_rate = g;
    do @(posedge clk); while (in_stall);
    sb.note_sample(a, g);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(int idx, logic [akf_pkg::DataW-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait until every owed result has transferred and the block takes input again.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Mostly plausible angles and rates, sometimes anything at all.
  function automatic logic signed [akf_pkg::DataW-1:0] pick_angle();
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 23592960)) - 32'sd11796480;  // +-180 deg
    endcase
  endfunction

  function automatic logic signed [akf_pkg::DataW-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 65536000)) - 32'sd32768000;  // +-500 deg/s
    endcase
  endfunction

  // Q8.24 register value for a phase: extremes on some phases, realistic on others.
  function automatic logic [akf_pkg::DataW-1:0] pick_reg(int idx, int phase);
    case (phase % 5)
      0: return (idx == akf_pkg::RegTimeStep || idx == akf_pkg::RegMeasureNoise)
                ? 32'h7fffffff : 32'h0;
      1: return (idx == akf_pkg::RegTimeStep) ? 32'h80000001 : 32'hffffffff;  // top bit dropped
      2: return (idx == akf_pkg::RegMeasureNoise) ? 32'h0 : $urandom_range(1, 200000);
      default: return $urandom_range(1, 1 << (16 + $urandom_range(0, 10)));
    endcase
  endfunction

  initial begin : stimulus
    int i, ph, r, per_phase;
    logic signed [akf_pkg::DataW-1:0] edge_vals[4];
    edge_vals = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'shffffffff};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: corner pairs of both fields, then a steady tilt with a gyro offset
    for (i = 0; i < 16; i++) send_sample(edge_vals[i / 4], edge_vals[i % 4]);
    for (i = 0; i < 8; i++) send_sample(32'sd2949120, 32'sd65536);  // 45 deg, 1 deg/s
    drain();
    // zero time step, zero measurement noise, and an ignored index
    write_reg(akf_pkg::RegTimeStep, 32'h0);
    write_reg(akf_pkg::RegMeasureNoise, 32'h0);
    write_reg(IgnoredIdx, 32'h12345);
    send_sample(32'sd655360, 32'sh80000000);
    drain();

    per_phase = RandItems / PhaseCount;
    for (ph = 0; ph < PhaseCount; ph++) begin
      drain();
      for (r = 0; r < 4; r++) write_reg(r, pick_reg(r, ph));
      if (ph == 4) write_reg(IgnoredIdx, $urandom());
      no_gaps = (ph % 3 == 1);
      for (i = 0; i < per_phase; i++) begin
        // mostly scaled-down picks of angle and rate, otherwise any values at all
        if ($urandom_range(0, 3) != 0)
          send_sample(pick_angle() >>> $urandom_range(0, 4), pick_rate() >>> $urandom_range(0, 6));
        else
          send_sample($urandom(), $urandom());
      end
    end
    in_valid = 1'b0;
    no_gaps = 1'b0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("Sent %0d samples over %0d register settings, %0d results checked.",
             samples_sent, reg_writes, sb.checked);
    $display("Mismatches: %0d, still owed: %0d.", sb.mismatches, sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
